// ----- rtl/core/wlpp_pkg.sv -----
// shared types and constants for the window/level pixel packer
package wlpp_pkg;

	// payload widths
	localparam int SAMPLE_BITS = 17;
	localparam int PIXEL_BITS  = 32;
	localparam int SHIFT_BITS  = 26;
	localparam int GAIN_BITS   = 32;
	localparam int MASK_BITS   = 32;
	localparam int COUNT_BITS  = 9;
	localparam int COMP_BITS   = 3;
	localparam int DATA_BITS   = 32;
	localparam int BYTE_BITS   = 8;
	localparam int LEAD_BITS   = $clog2(MASK_BITS);

	// fixed point: sample moves up by the shift fraction bits, product keeps 24 fraction bits
	localparam int SHIFT_FRAC  = 8;
	localparam int FRAC_BITS   = 24;
	localparam int SCALED_BITS = SAMPLE_BITS + SHIFT_FRAC;
	localparam int SUM_BITS    = ((SCALED_BITS > SHIFT_BITS) ? SCALED_BITS : SHIFT_BITS) + 1;
	localparam int PROD_BITS   = SUM_BITS + GAIN_BITS;

	// byte placement under a colour mask starts at the top byte of the mask word
	localparam int BYTE_TOP_SHIFT = MASK_BITS - BYTE_BITS;
	localparam logic [BYTE_BITS-1:0] BYTE_MAX = '1;

	// register reset values
	localparam logic [COMP_BITS-1:0]  RST_COMPONENTS  = COMP_BITS'(1);
	localparam logic [GAIN_BITS-1:0]  RST_GAIN        = GAIN_BITS'(65536);
	localparam logic [MASK_BITS-1:0]  RST_RED_FIELD   = MASK_BITS'(32'h00FF_0000);
	localparam logic [MASK_BITS-1:0]  RST_GREEN_FIELD = MASK_BITS'(32'h0000_FF00);
	localparam logic [MASK_BITS-1:0]  RST_BLUE_FIELD  = MASK_BITS'(32'h0000_00FF);
	localparam logic [COUNT_BITS-1:0] RST_COLOR_CNT   = COUNT_BITS'(150);

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_INDEX_MODE  = 3'd0,
		REG_COMPONENTS  = 3'd1,
		REG_LEVEL_SHIFT = 3'd2,
		REG_GAIN_SCALE  = 3'd3,
		REG_RED_FIELD   = 3'd4,
		REG_GREEN_FIELD = 3'd5,
		REG_BLUE_FIELD  = 3'd6,
		REG_COLOR_COUNT = 3'd7
	} cfg_reg_t;

	// configuration as seen by the datapath, with derived mask alignment and index top
	typedef struct packed {
		logic                         index_mode;
		logic [COMP_BITS-1:0]         components;
		logic signed [SHIFT_BITS-1:0] level_shift;
		logic signed [GAIN_BITS-1:0]  gain_scale;
		logic [MASK_BITS-1:0]         red_field;
		logic [MASK_BITS-1:0]         green_field;
		logic [MASK_BITS-1:0]         blue_field;
		logic [LEAD_BITS-1:0]         red_lead;
		logic [LEAD_BITS-1:0]         green_lead;
		logic [LEAD_BITS-1:0]         blue_lead;
		logic [BYTE_BITS-1:0]         index_top;
	} cfg_t;

endpackage

// ----- rtl/core/wlpp_cfg_regs.sv -----
// configuration registers with mask leading-zero counts and index top value
module wlpp_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  wlpp_pkg::cfg_reg_t        cfg_index,
	input  logic [wlpp_pkg::DATA_BITS-1:0] cfg_data,
	output wlpp_pkg::cfg_t            cfg
);
	import wlpp_pkg::*;

	logic                    index_mode_q;
	logic [COMP_BITS-1:0]    components_q;
	logic [SHIFT_BITS-1:0]   level_shift_q;
	logic [GAIN_BITS-1:0]    gain_scale_q;
	logic [MASK_BITS-1:0]    red_field_q;
	logic [MASK_BITS-1:0]    green_field_q;
	logic [MASK_BITS-1:0]    blue_field_q;
	logic [COUNT_BITS-1:0]   color_count_q;
	logic [LEAD_BITS-1:0]    red_lead_q;
	logic [LEAD_BITS-1:0]    green_lead_q;
	logic [LEAD_BITS-1:0]    blue_lead_q;
	logic [BYTE_BITS-1:0]    index_top_q;
	logic [BYTE_BITS-1:0]    index_top_d;

	// leading zeros of a mask by a five-step binary search; zero mask gives all ones
	function automatic logic [LEAD_BITS-1:0] lead_zeros(input logic [MASK_BITS-1:0] m);
		logic [MASK_BITS-1:0] x;
		logic [LEAD_BITS-1:0] n;
		x = m;
		n = '0;
		for (int i = LEAD_BITS - 1; i >= 0; i--) begin
			if ((x >> (MASK_BITS - (1 << i))) == '0) begin
				n[i] = 1'b1;
				x = x << (1 << i);
			end
		end
		return n;
	endfunction

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_mode_q  <= 1'b0;
			components_q  <= RST_COMPONENTS;
			level_shift_q <= '0;
			gain_scale_q  <= RST_GAIN;
			red_field_q   <= RST_RED_FIELD;
			green_field_q <= RST_GREEN_FIELD;
			blue_field_q  <= RST_BLUE_FIELD;
			color_count_q <= RST_COLOR_CNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INDEX_MODE:  index_mode_q  <= cfg_data[0];
				REG_COMPONENTS:  components_q  <= cfg_data[COMP_BITS-1:0];
				REG_LEVEL_SHIFT: level_shift_q <= cfg_data[SHIFT_BITS-1:0];
				REG_GAIN_SCALE:  gain_scale_q  <= cfg_data[GAIN_BITS-1:0];
				REG_RED_FIELD:   red_field_q   <= cfg_data[MASK_BITS-1:0];
				REG_GREEN_FIELD: green_field_q <= cfg_data[MASK_BITS-1:0];
				REG_BLUE_FIELD:  blue_field_q  <= cfg_data[MASK_BITS-1:0];
				REG_COLOR_COUNT: color_count_q <= cfg_data[COUNT_BITS-1:0];
				default:         color_count_q <= color_count_q;
			endcase
		end
	end

	// top palette index: zero count acts as one, counts above 256 saturate
	always_comb begin
		priority if (color_count_q == '0) begin
			index_top_d = '0;
		end else if (color_count_q > COUNT_BITS'(256)) begin
			index_top_d = BYTE_MAX;
		end else begin
			index_top_d = BYTE_BITS'(color_count_q - COUNT_BITS'(1));
		end
	end

	// derived values are registered and follow the registers in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_lead_q   <= lead_zeros(RST_RED_FIELD);
			green_lead_q <= lead_zeros(RST_GREEN_FIELD);
			blue_lead_q  <= lead_zeros(RST_BLUE_FIELD);
			index_top_q  <= BYTE_BITS'(RST_COLOR_CNT - COUNT_BITS'(1));
		end else begin
			red_lead_q   <= lead_zeros(red_field_q);
			green_lead_q <= lead_zeros(green_field_q);
			blue_lead_q  <= lead_zeros(blue_field_q);
			index_top_q  <= index_top_d;
		end
	end

	// bundle for the datapath
	always_comb begin
		cfg.index_mode  = index_mode_q;
		cfg.components  = components_q;
		cfg.level_shift = level_shift_q;
		cfg.gain_scale  = gain_scale_q;
		cfg.red_field   = red_field_q;
		cfg.green_field = green_field_q;
		cfg.blue_field  = blue_field_q;
		cfg.red_lead    = red_lead_q;
		cfg.green_lead  = green_lead_q;
		cfg.blue_lead   = blue_lead_q;
		cfg.index_top   = index_top_q;
	end

endmodule

// ----- rtl/core/wlpp_scale.sv -----
// one channel: level shift add, then gain multiply, each followed by a register
module wlpp_scale (
	input  logic                                   clk,
	input  logic signed [wlpp_pkg::SAMPLE_BITS-1:0] sample_s1,
	input  logic signed [wlpp_pkg::SHIFT_BITS-1:0]  level_shift,
	input  logic signed [wlpp_pkg::GAIN_BITS-1:0]   gain_scale,
	output logic signed [wlpp_pkg::PROD_BITS-1:0]   product_s3
);
	import wlpp_pkg::*;

	logic signed [SUM_BITS-1:0]  scaled;
	logic signed [SUM_BITS-1:0]  shift_ext;
	logic signed [SUM_BITS-1:0]  sum_s2;
	logic signed [PROD_BITS-1:0] sum_ext;
	logic signed [PROD_BITS-1:0] gain_ext;

	// sample in Q.8 plus the shift; cannot overflow the sum width
	assign scaled    = SUM_BITS'($signed({sample_s1, SHIFT_FRAC'(0)}));
	assign shift_ext = SUM_BITS'(level_shift);

	always_ff @(posedge clk) begin
		sum_s2 <= scaled + shift_ext;
	end

	// signed product in Q.24
	assign sum_ext  = PROD_BITS'(sum_s2);
	assign gain_ext = PROD_BITS'(gain_scale);

	always_ff @(posedge clk) begin
		product_s3 <= sum_ext * gain_ext;
	end

endmodule

// ----- rtl/core/wlpp_pack.sv -----
// clamp of the three channel products and packing under the colour masks
module wlpp_pack (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid_s3,
	input  wlpp_pkg::cfg_t                         cfg,
	input  logic signed [wlpp_pkg::PROD_BITS-1:0]   red_prod_s3,
	input  logic signed [wlpp_pkg::PROD_BITS-1:0]   green_prod_s3,
	input  logic signed [wlpp_pkg::PROD_BITS-1:0]   blue_prod_s3,
	output logic                                   done,
	output logic [wlpp_pkg::PIXEL_BITS-1:0]         pixel_word
);
	import wlpp_pkg::*;

	localparam int INT_BITS = PROD_BITS - FRAC_BITS - 1;

	logic                   gray;
	logic                   use_index;
	logic [BYTE_BITS-1:0]   red_top;
	logic [BYTE_BITS-1:0]   red_byte;
	logic [BYTE_BITS-1:0]   green_byte;
	logic [BYTE_BITS-1:0]   blue_byte;
	logic [BYTE_BITS-1:0]   green_sel;
	logic [BYTE_BITS-1:0]   blue_sel;
	logic [MASK_BITS-1:0]   packed_word;
	logic [PIXEL_BITS-1:0]  word_d;
	logic [PIXEL_BITS-1:0]  pixel_word_q;
	logic                   done_q;

	// non-positive products give zero, else the integer part saturated at top
	function automatic logic [BYTE_BITS-1:0] clamp_byte(
		input logic signed [PROD_BITS-1:0] p,
		input logic [BYTE_BITS-1:0]        top
	);
		logic [INT_BITS-1:0]  v;
		logic [BYTE_BITS-1:0] res;
		v = p[PROD_BITS-2:FRAC_BITS];
		if (p[PROD_BITS-1]) begin
			res = '0;
		end else if (v > INT_BITS'(top)) begin
			res = top;
		end else begin
			res = v[BYTE_BITS-1:0];
		end
		return res;
	endfunction

	// byte aligned to the top set bit of the mask, then masked
	function automatic logic [MASK_BITS-1:0] place_under(
		input logic [MASK_BITS-1:0] mask,
		input logic [LEAD_BITS-1:0] lead,
		input logic [BYTE_BITS-1:0] b
	);
		logic [MASK_BITS-1:0] top_aligned;
		top_aligned = {b, BYTE_TOP_SHIFT'(0)};
		return mask & (top_aligned >> lead);
	endfunction

	// channel selection by component count
	assign gray      = (cfg.components[COMP_BITS-1:1] == '0);
	assign use_index = gray && cfg.index_mode;
	assign red_top   = use_index ? cfg.index_top : BYTE_MAX;

	assign red_byte   = clamp_byte(red_prod_s3, red_top);
	assign green_byte = clamp_byte(green_prod_s3, BYTE_MAX);
	assign blue_byte  = clamp_byte(blue_prod_s3, BYTE_MAX);

	always_comb begin
		if (gray) begin
			green_sel = red_byte;
			blue_sel  = red_byte;
		end else if (cfg.components == COMP_BITS'(2)) begin
			green_sel = green_byte;
			blue_sel  = red_byte;
		end else begin
			green_sel = green_byte;
			blue_sel  = blue_byte;
		end
	end

	// packed word or palette index
	assign packed_word = place_under(cfg.red_field, cfg.red_lead, red_byte)
		| place_under(cfg.green_field, cfg.green_lead, green_sel)
		| place_under(cfg.blue_field, cfg.blue_lead, blue_sel);

	assign word_d = use_index ? PIXEL_BITS'(red_byte) : packed_word[PIXEL_BITS-1:0];

	// result register
	always_ff @(posedge clk) begin
		if (valid_s3) begin
			pixel_word_q <= word_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s3;
		end
	end

	assign done       = done_q;
	assign pixel_word = pixel_word_q;

endmodule

// ----- rtl/core/window_level_pixel_packer.sv -----
// top level of the window/level pixel packer
//
// Maps up to three integer samples of a pixel through a window/level ramp
// (shift, then signed gain, clamp to a byte) and packs the channel bytes
// under the red, green and blue masks into one display word, or gives a
// palette index byte in index mode with one or no component.
// Input: a request is taken at each rising edge with start high and busy low;
// busy is high only in the first cycle after reset, so one pixel per clock.
// Output: done is high for one cycle with pixel_word valid; the receiver
// cannot stall and there is no back pressure.
// Pipeline: an accepted request passes the input register, shift add,
// gain multiply, and clamp and pack into the result register on its way
// to done; throughput is one pixel per cycle, with a single 27x32 multiplier per channel.
// Configuration: cfg_valid/cfg_ready write channel, register index and data;
// cfg_ready is always high. Write only with no pixel in flight.
// Reset: asynchronous, active low; registers return to their defaults and
// the pipeline empties.
module window_level_pixel_packer (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [wlpp_pkg::SAMPLE_BITS-1:0]  sample_first,
	input  logic signed [wlpp_pkg::SAMPLE_BITS-1:0]  sample_second,
	input  logic signed [wlpp_pkg::SAMPLE_BITS-1:0]  sample_third,
	output logic                                    done,
	output logic [wlpp_pkg::PIXEL_BITS-1:0]          pixel_word,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  wlpp_pkg::cfg_reg_t                      cfg_index,
	input  logic [wlpp_pkg::DATA_BITS-1:0]           cfg_data
);
	import wlpp_pkg::*;

	cfg_t                          cfg;
	logic                          busy_q;
	logic                          accept;
	logic                          valid_s1;
	logic                          valid_s2;
	logic                          valid_s3;
	logic signed [SAMPLE_BITS-1:0] first_s1;
	logic signed [SAMPLE_BITS-1:0] second_s1;
	logic signed [SAMPLE_BITS-1:0] third_s1;
	logic signed [PROD_BITS-1:0]   red_prod_s3;
	logic signed [PROD_BITS-1:0]   green_prod_s3;
	logic signed [PROD_BITS-1:0]   blue_prod_s3;

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	// busy only right after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// request valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// input sample register
	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1  <= sample_first;
			second_s1 <= sample_second;
			third_s1  <= sample_third;
		end
	end

	wlpp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wlpp_scale u_scale_red (
		.clk         (clk),
		.sample_s1   (first_s1),
		.level_shift (cfg.level_shift),
		.gain_scale  (cfg.gain_scale),
		.product_s3  (red_prod_s3)
	);

	wlpp_scale u_scale_green (
		.clk         (clk),
		.sample_s1   (second_s1),
		.level_shift (cfg.level_shift),
		.gain_scale  (cfg.gain_scale),
		.product_s3  (green_prod_s3)
	);

	wlpp_scale u_scale_blue (
		.clk         (clk),
		.sample_s1   (third_s1),
		.level_shift (cfg.level_shift),
		.gain_scale  (cfg.gain_scale),
		.product_s3  (blue_prod_s3)
	);

	wlpp_pack u_pack (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s3      (valid_s3),
		.cfg           (cfg),
		.red_prod_s3   (red_prod_s3),
		.green_prod_s3 (green_prod_s3),
		.blue_prod_s3  (blue_prod_s3),
		.done          (done),
		.pixel_word    (pixel_word)
	);

	// every accepted request gives its result on done
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##3 done)
		else $error("accepted request produced no result");

	// no result without an earlier accepted request
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result without a request");

	// palette index results keep the upper bits clear
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && cfg.index_mode && (cfg.components[COMP_BITS-1:1] == '0))
		|-> (pixel_word[PIXEL_BITS-1:BYTE_BITS] == '0))
		else $error("index result has upper bits set");

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the window/level pixel packer
`timescale 1ns / 100ps

module tb_top;
	import wlpp_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 4;
	localparam int LATENCY = 4;
	localparam int TAIL_CYCLES = LATENCY + 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_PIXELS = 65;
	localparam int RANDOM_SETUPS = 14;
	localparam int MAX_PRINTS = 100;
	localparam longint SUM_CAP = 64'sd4294967295;
	localparam int UNITY_RAMP = 255 * 65536;

	// expected display words, worked out from the current register copy
	class packed_pixel_book;
		logic                         index_mode = 1'b0;
		logic [COMP_BITS-1:0]         components = RST_COMPONENTS;
		logic signed [SHIFT_BITS-1:0] level_shift = '0;
		logic signed [GAIN_BITS-1:0]  gain_scale = RST_GAIN;
		logic [MASK_BITS-1:0]         red_field = RST_RED_FIELD;
		logic [MASK_BITS-1:0]         green_field = RST_GREEN_FIELD;
		logic [MASK_BITS-1:0]         blue_field = RST_BLUE_FIELD;
		logic [COUNT_BITS-1:0]        color_count = RST_COLOR_CNT;
		logic [PIXEL_BITS-1:0]        pending_words[$];
		int                           errors = 0;

		function void write_reg(cfg_reg_t idx, logic [DATA_BITS-1:0] data);
			case (idx)
				REG_INDEX_MODE:  index_mode = data[0];
				REG_COMPONENTS:  components = data[COMP_BITS-1:0];
				REG_LEVEL_SHIFT: level_shift = data[SHIFT_BITS-1:0];
				REG_GAIN_SCALE:  gain_scale = data[GAIN_BITS-1:0];
				REG_RED_FIELD:   red_field = data[MASK_BITS-1:0];
				REG_GREEN_FIELD: green_field = data[MASK_BITS-1:0];
				REG_BLUE_FIELD:  blue_field = data[MASK_BITS-1:0];
				REG_COLOR_COUNT: color_count = data[COUNT_BITS-1:0];
				default: ;
			endcase
		endfunction

		// shift, gain, then clamp to 0..top
		function logic [BYTE_BITS-1:0] ramp_byte(logic signed [SAMPLE_BITS-1:0] sample,
				logic [BYTE_BITS-1:0] top);
			longint sum;
			longint prod;
			longint mag;
			sum = longint'(sample) * 256 + longint'(level_shift);
			if (sum > SUM_CAP)
				sum = SUM_CAP;
			if (sum < -SUM_CAP)
				sum = -SUM_CAP;
			prod = sum * longint'(gain_scale);
			if (prod <= 0)
				return '0;
			mag = prod >>> FRAC_BITS;
			if (mag > longint'(top))
				mag = longint'(top);
			return mag[BYTE_BITS-1:0];
		endfunction

		// byte lands under the top bits of the mask, aligned back down
		function logic [PIXEL_BITS-1:0] under_mask(logic [MASK_BITS-1:0] mask,
				logic [BYTE_BITS-1:0] chan);
			logic [MASK_BITS-1:0] aligned;
			logic [MASK_BITS-1:0] spread;
			int lead;
			if (mask == '0)
				return '0;
			aligned = mask;
			lead = 0;
			while (!aligned[MASK_BITS-1]) begin
				aligned = aligned << 1;
				lead++;
			end
			spread = MASK_BITS'(chan) << BYTE_TOP_SHIFT;
			return PIXEL_BITS'((aligned & spread) >> lead);
		endfunction

		function void note_pixel(logic signed [SAMPLE_BITS-1:0] first,
				logic signed [SAMPLE_BITS-1:0] second, logic signed [SAMPLE_BITS-1:0] third);
			logic [BYTE_BITS-1:0] red;
			logic [BYTE_BITS-1:0] green;
			logic [BYTE_BITS-1:0] blue;
			logic [BYTE_BITS-1:0] top;
			logic [PIXEL_BITS-1:0] word;
			if (components <= 1 && index_mode) begin
				// palette index, top clipped to a byte
				if (color_count == '0)
					top = '0;
				else if (color_count > 256)
					top = BYTE_MAX;
				else
					top = BYTE_BITS'(color_count - 1);
				word = PIXEL_BITS'(ramp_byte(first, top));
			end else begin
				red = ramp_byte(first, BYTE_MAX);
				if (components <= 1) begin
					green = red;
					blue = red;
				end else begin
					green = ramp_byte(second, BYTE_MAX);
					blue = (components >= 3) ? ramp_byte(third, BYTE_MAX) : red;
				end
				word = under_mask(red_field, red) | under_mask(green_field, green) |
					under_mask(blue_field, blue);
			end
			pending_words.push_back(word);
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("tb_top: mismatch at %0t: %s", $realtime, what);
		endtask

		task check_pixel(logic [PIXEL_BITS-1:0] word);
			logic [PIXEL_BITS-1:0] want;
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("pixel_word %h with no request waiting", word));
			end else begin
				want = pending_words.pop_front();
				if (word !== want)
					report_mismatch($sformatf("pixel_word got %h, expected %h", word, want));
			end
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic signed [SAMPLE_BITS-1:0] sample_first;
	logic signed [SAMPLE_BITS-1:0] sample_second;
	logic signed [SAMPLE_BITS-1:0] sample_third;
	logic                          done;
	logic [PIXEL_BITS-1:0]         pixel_word;
	logic                          cfg_valid;
	logic                          cfg_ready;
	cfg_reg_t                      cfg_index;
	logic [DATA_BITS-1:0]          cfg_data;

	packed_pixel_book book = new();
	int cycle_count = 0;
	int win_lo = 0;
	int win_width = 256;
	int corner_vals[8] = '{-32768, -1, 0, 1, 255, 256, 32767, 65535};

	window_level_pixel_packer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.sample_first  (sample_first),
		.sample_second (sample_second),
		.sample_third  (sample_third),
		.done          (done),
		.pixel_word    (pixel_word),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// observe accepted requests, register writes and results
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				book.note_pixel(sample_first, sample_second, sample_third);
			if (cfg_valid && cfg_ready)
				book.write_reg(cfg_index, cfg_data);
			if (done)
				book.check_pixel(pixel_word);
		end
	end

	// one register write, bits above the register width filled with noise
	task automatic write_reg(cfg_reg_t idx, logic [DATA_BITS-1:0] value, int bits);
		logic [DATA_BITS-1:0] keep;
		keep = (bits >= DATA_BITS) ? '1 : ((DATA_BITS'(1) << bits) - 1);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= (value & keep) | ($urandom() & ~keep);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic mode, int comps, int shift, logic [31:0] gain,
			logic [31:0] rmask, logic [31:0] gmask, logic [31:0] bmask, int count);
		write_reg(REG_INDEX_MODE, DATA_BITS'(mode), 1);
		write_reg(REG_COMPONENTS, DATA_BITS'(comps), COMP_BITS);
		write_reg(REG_LEVEL_SHIFT, DATA_BITS'(shift), SHIFT_BITS);
		write_reg(REG_GAIN_SCALE, gain, GAIN_BITS);
		write_reg(REG_RED_FIELD, rmask, MASK_BITS);
		write_reg(REG_GREEN_FIELD, gmask, MASK_BITS);
		write_reg(REG_BLUE_FIELD, bmask, MASK_BITS);
		write_reg(REG_COLOR_COUNT, DATA_BITS'(count), COUNT_BITS);
	endtask

	// hold one request until the block takes it; start stays high afterwards
	task automatic send_pixel(int first, int second, int third);
		start <= 1'b1;
		sample_first <= SAMPLE_BITS'(first);
		sample_second <= SAMPLE_BITS'(second);
		sample_third <= SAMPLE_BITS'(third);
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// stop sending until every expected word is back, then let the pipe settle
	task automatic drain_results();
		start <= 1'b0;
		while (book.pending_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic run_corners();
		for (int i = 0; i < 8; i++)
			send_pixel(corner_vals[i], corner_vals[7 - i], corner_vals[(i + 3) % 8]);
		drain_results();
	endtask

	// samples: mostly inside the current window, some anywhere, some at the ends
	function automatic int pick_sample();
		int v;
		case ($urandom_range(0, 4))
			0: v = int'($urandom_range(0, 98303)) - 32768;
			1: v = corner_vals[$urandom_range(0, 7)];
			default: v = win_lo + int'($urandom_range(0, win_width + 4)) - 2;
		endcase
		if (v < -32768)
			v = -32768;
		if (v > 65535)
			v = 65535;
		return v;
	endfunction

	function automatic logic [31:0] pick_mask();
		logic [32:0] field;
		int len;
		int pos;
		len = $urandom_range(1, 12);
		pos = $urandom_range(0, 32 - len);
		field = ((33'd1 << len) - 1) << pos;
		case ($urandom_range(0, 5))
			0: return '0;
			1: return $urandom();
			2: return '1;
			default: return field[31:0];
		endcase
	endfunction

	// random setup: components, window width, low end, ramp direction, gain, shift, masks, palette count
	task automatic random_setup();
		int comps;
		int gain;
		int shift;
		int count;
		bit falling;
		case ($urandom_range(0, 9))
			0: comps = 0;
			1, 2, 3: comps = 1;
			4, 5: comps = 2;
			6, 7, 8: comps = 3;
			default: comps = $urandom_range(4, 7);
		endcase
		win_width = $urandom_range(1, 1 << $urandom_range(1, 16));
		win_lo = int'($urandom_range(0, 98303)) - 32768;
		falling = 1'($urandom_range(0, 1));
		gain = UNITY_RAMP / win_width;
		if (falling)
			gain = -gain;
		shift = -(win_lo + (falling ? win_width : 0)) * 256 + int'($urandom_range(0, 255));
		if ($urandom_range(0, 5) == 0)
			gain = $urandom();
		if ($urandom_range(0, 7) == 0)
			shift = $urandom();
		count = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
		set_config(1'($urandom_range(0, 1)), comps, shift, gain, pick_mask(), pick_mask(),
			pick_mask(), count);
	endtask

	task automatic run_pixels(int count, int idle_pct, bit hold_midway);
		for (int k = 0; k < count; k++) begin
			if (hold_midway && k == count / 2)
				drain_results();
			if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
				pause_sender($urandom_range(1, 3));
			send_pixel(pick_sample(), pick_sample(), pick_sample());
		end
		drain_results();
	endtask

	function automatic int idle_for(int phase);
		case (phase % 4)
			1: return 52;
			3: return 30;
			default: return 0;
		endcase
	endfunction

	// stimulus
	initial begin
		int phase;
		arst_n <= 1'b0;
		start <= 1'b0;
		sample_first <= '0;
		sample_second <= '0;
		sample_third <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_INDEX_MODE;
		cfg_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: gray at unit gain
		win_lo = 0;
		win_width = 255;
		run_corners();

		phase = 0;
		// index mode, zero components, empty palette
		set_config(1'b1, 0, 0, 32'd65536, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 0);
		run_pixels(PHASE_PIXELS, idle_for(phase++), 1'b0);
		// index mode, palette count above a byte
		win_lo = 1000;
		win_width = 4000;
		set_config(1'b1, 1, -1000 * 256, UNITY_RAMP / 4000, 32'h00FF_0000, 32'h0000_FF00,
			32'h0000_00FF, 300);
		run_pixels(PHASE_PIXELS, idle_for(phase++), 1'b0);
		// largest shift and gain, single palette entry
		set_config(1'b1, 1, 33554431, 32'h7FFF_FFFF, 32'h00FF_0000, 32'h0000_FF00,
			32'h0000_00FF, 1);
		run_pixels(PHASE_PIXELS, idle_for(phase++), 1'b1);
		// index mode with two components gives a packed word
		win_lo = -200;
		win_width = 600;
		set_config(1'b1, 2, 200 * 256, UNITY_RAMP / 600, 32'h0000_F800, 32'h0000_07E0,
			32'h0000_001F, 256);
		run_pixels(PHASE_PIXELS, idle_for(phase++), 1'b0);
		// most negative shift and gain, odd masks
		set_config(1'b0, 3, -33554432, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0001,
			32'h0000_0001, 511);
		run_corners();
		run_pixels(PHASE_PIXELS, idle_for(phase++), 1'b0);
		// zero gain, components above three
		set_config(1'b0, 7, 12345, 32'd0, 32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00, 150);
		run_pixels(PHASE_PIXELS, idle_for(phase++), 1'b0);
		// zero red mask, inverted ramp
		win_lo = 0;
		win_width = 1024;
		set_config(1'b0, 4, -1024 * 256, -(UNITY_RAMP / 1024), 32'd0, 32'h0003_FC00,
			32'h0000_03FF, 150);
		run_pixels(PHASE_PIXELS, idle_for(phase++), 1'b1);
		// index bit set with many components
		set_config(1'b1, 5, -1024 * 256, -(UNITY_RAMP / 1024), 32'h0000_0F00,
			32'h0000_00F0, 32'h0000_000F, 128);
		run_pixels(PHASE_PIXELS, idle_for(phase++), 1'b0);

		// random settings
		for (int n = 0; n < RANDOM_SETUPS; n++) begin
			random_setup();
			run_pixels(PHASE_PIXELS, idle_for(phase), (phase % 5) == 2);
			phase++;
		end

		drain_results();
		if (book.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
